### hw/rtl/encoder_window_pi_position_regulator_defines.svh
// Assertion macros for the encoder window PI position regulator.
// The macros expect clk_i and rst_ni to be visible where they are used.
`ifndef ENCODER_WINDOW_PI_POSITION_REGULATOR_DEFINES_SVH
`define ENCODER_WINDOW_PI_POSITION_REGULATOR_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define EWPR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define EWPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ewpr_pkg.sv
// Shared constants, register codes and stage payload types of the regulator.
// Used by ewpr_cfg, ewpr_window, ewpr_integ, ewpr_drive and the top level; depends on nothing.
package ewpr_pkg;

  localparam logic [15:0] HalfScale = 16'h8000;
  localparam logic [12:0] Recip25 = 13'd5243;
  localparam logic [14:0] Recip20 = 15'd26215;
  localparam logic [6:0] Div100 = 7'd100;
  localparam logic signed [12:0] CmdLimit = 13'sd127;
  localparam logic [6:0] DriveCap = 7'd120;

  typedef enum logic [1:0] {
    RegCalRight    = 2'd0,
    RegCalLeft     = 2'd1,
    RegTravelRange = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic        load_right;
    logic        load_left;
    logic [14:0] right_point;
    logic [14:0] left_point;
    logic [15:0] travel_range;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] err;
    logic [15:0]        position;
  } s1_t;

  typedef struct packed {
    logic [27:0] prod;
    logic        neg;
    logic [15:0] err_mag;
    logic [15:0] position;
  } s2_t;

  typedef struct packed {
    logic signed [15:0] integral;
    logic signed [11:0] q25;
    logic [15:0]        position;
  } s3_t;

endpackage

### hw/rtl/ewpr_if.sv
// Valid/ready channel interfaces for the regulator's input and result items.
// Payload widths follow the item fields; no package dependency.
interface ewpr_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_count;
  logic [7:0]  target_byte;

  modport source (output valid, output raw_count, output target_byte, input ready);
  modport sink (input valid, input raw_count, input target_byte, output ready);
endinterface

interface ewpr_out_if;
  logic        valid;
  logic        ready;
  logic        direction;
  logic [6:0]  drive_level;
  logic [15:0] position;

  modport source (output valid, output direction, output drive_level, output position,
                  input ready);
  modport sink (input valid, input direction, input drive_level, input position,
                output ready);
endinterface

### hw/rtl/ewpr_cfg.sv
// APB-style register file holding the endpoints and the travel range.
// Depends on ewpr_pkg for the register codes and the cfg_t bundle.
module ewpr_cfg import ewpr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic [14:0] right_q, right_d;
  logic [14:0] left_q, left_d;
  logic [15:0] range_q, range_d;
  logic        wr_en;
  reg_idx_e    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);

  always_comb begin
    right_d = right_q;
    left_d  = left_q;
    range_d = range_q;
    cfg_o.load_right = 1'b0;
    cfg_o.load_left  = 1'b0;
    prdata = 32'd0;
    case (idx)
      RegCalRight: begin
        prdata = {17'd0, right_q};
        if (wr_en) begin
          right_d = pwdata[14:0];
          cfg_o.load_right = 1'b1;
        end
      end
      RegCalLeft: begin
        prdata = {17'd0, left_q};
        if (wr_en) begin
          left_d = pwdata[14:0];
          cfg_o.load_left = 1'b1;
        end
      end
      RegTravelRange: begin
        prdata = {16'd0, range_q};
        if (wr_en) begin
          range_d = pwdata[15:0];
        end
      end
      default: begin
        prdata = 32'd0;
      end
    endcase
    cfg_o.right_point  = right_d;
    cfg_o.left_point   = left_d;
    cfg_o.travel_range = range_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_q <= '0;
      left_q  <= '0;
      range_q <= '0;
    end else begin
      right_q <= right_d;
      left_q  <= left_d;
      range_q <= range_d;
    end
  end

endmodule

### hw/rtl/ewpr_window.sv
// Travel window tracking, position normalisation and position error stage.
// Depends on ewpr_pkg; holds the right and left edge state.
module ewpr_window import ewpr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [15:0] raw_count_i,
  input  logic [7:0]  target_byte_i,
  output logic        valid_o,
  input  logic        ready_i,
  output s1_t         data_o
);

  logic [15:0] right_q, right_d, left_q, left_d;
  logic [15:0] right_new, left_new;
  logic [16:0] v_w, r_w, l_w, rng_w;
  logic [15:0] rng, sum_w, position, target;
  logic        outside, slide_right, load, valid_q;
  s1_t         data_q;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign rng     = cfg_i.travel_range;

  always_comb begin
    v_w   = {1'b0, raw_count_i};
    r_w   = {1'b0, right_q};
    l_w   = {1'b0, left_q};
    rng_w = {1'b0, rng};
    sum_w = raw_count_i + rng;
    outside = ((left_q > right_q) && ((raw_count_i > left_q) || (raw_count_i < right_q))) ||
              ((left_q < right_q) && (raw_count_i < right_q) && (raw_count_i > left_q));
    slide_right = (v_w > (l_w + rng_w)) || ((raw_count_i < right_q) && ((v_w + rng_w) > r_w));
    right_new = right_q;
    left_new  = left_q;
    if (outside) begin
      if (slide_right) begin
        right_new = raw_count_i;
        left_new  = {1'b0, sum_w[14:0]};
      end else begin
        left_new = raw_count_i;
        if (raw_count_i >= rng) begin
          right_new = raw_count_i - rng;
        end else begin
          right_new = raw_count_i - rng + HalfScale;
        end
      end
    end
    if ((left_new > right_new) || (raw_count_i >= right_new)) begin
      position = raw_count_i - right_new;
    end else begin
      position = raw_count_i + HalfScale - right_new;
    end
    target = {8'd0, target_byte_i} * {8'd0, rng[15:8]};

    right_d = right_q;
    left_d  = left_q;
    if (cfg_i.load_right) begin
      right_d = {1'b0, cfg_i.right_point};
    end else if (load) begin
      right_d = right_new;
    end
    if (cfg_i.load_left) begin
      left_d = {1'b0, cfg_i.left_point};
    end else if (load) begin
      left_d = left_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_q <= '0;
      left_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      right_q <= right_d;
      left_q  <= left_d;
      if (ready_o) begin
        valid_q <= valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q.err      <= $signed(position - target);
      data_q.position <= position;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### hw/rtl/ewpr_integ.sv
// Error scaling and integral update: a reciprocal product stage, then the
// saturating integral accumulator. Depends on ewpr_pkg.
module ewpr_integ import ewpr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  s1_t  data_i,
  output logic valid_o,
  input  logic ready_i,
  output s3_t  data_o
);

  logic               v2_q, v3_q, ready2, load2, load3;
  s2_t                s2_q, s2_d;
  s3_t                s3_q, s3_d;
  logic signed [15:0] integ_q;
  logic [28:0]        prod_full;
  logic [8:0]         q100;
  logic [10:0]        q25;
  logic [15:0]        back;
  logic               rem_nz;
  logic signed [9:0]  step;
  logic signed [16:0] sum, sum_c;
  logic signed [15:0] integ_new;

  assign ready2  = !v3_q || ready_i;
  assign ready_o = !v2_q || ready2;
  assign load2   = valid_i && ready_o;
  assign load3   = v2_q && ready2;

  always_comb begin
    s2_d.neg      = data_i.err[15];
    s2_d.err_mag  = data_i.err[15] ? 16'(-data_i.err) : 16'(data_i.err);
    prod_full     = {13'd0, s2_d.err_mag} * {16'd0, Recip25};
    s2_d.prod     = prod_full[27:0];
    s2_d.position = data_i.position;
  end

  always_comb begin
    q100   = s2_q.prod[27:19];
    q25    = s2_q.prod[27:17];
    back   = {7'd0, q100} * {9'd0, Div100};
    rem_nz = (back != s2_q.err_mag);
    step   = s2_q.neg ? -$signed({1'b0, q100}) : $signed({1'b0, q100});
    sum    = {integ_q[15], integ_q} + {{7{step[9]}}, step};
    if (rem_nz && s2_q.neg && (sum > 17'sd0)) begin
      sum_c = sum - 17'sd1;
    end else if (rem_nz && !s2_q.neg && (sum < 17'sd0)) begin
      sum_c = sum + 17'sd1;
    end else begin
      sum_c = sum;
    end
    if (sum_c > 17'sd32767) begin
      integ_new = 16'sh7FFF;
    end else if (sum_c < -17'sd32768) begin
      integ_new = 16'sh8000;
    end else begin
      integ_new = sum_c[15:0];
    end
    s3_d.integral = integ_new;
    s3_d.q25      = s2_q.neg ? -$signed({1'b0, q25}) : $signed({1'b0, q25});
    s3_d.position = s2_q.position;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      integ_q <= '0;
    end else begin
      if (ready_o) begin
        v2_q <= valid_i;
      end
      if (ready2) begin
        v3_q <= v2_q;
      end
      if (load3) begin
        integ_q <= integ_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load2) begin
      s2_q <= s2_d;
    end
    if (load3) begin
      s3_q <= s3_d;
    end
  end

  assign valid_o = v3_q;
  assign data_o  = s3_q;

endmodule

### hw/rtl/ewpr_drive.sv
// Command forming and output register: integral term, clamp, direction and
// drive level. Depends on ewpr_pkg.
module ewpr_drive import ewpr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  s3_t         data_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic        direction_o,
  output logic [6:0]  drive_level_o,
  output logic [15:0] position_o
);

  logic               valid_q, load, dir_q;
  logic [6:0]         level_q, level_d, cmd_mag;
  logic [15:0]        pos_q, i_mag;
  logic [30:0]        prod;
  logic [10:0]        q20;
  logic signed [11:0] q20s;
  logic signed [12:0] cmd, cmd_c;
  logic [7:0]         lvl2;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    i_mag = data_i.integral[15] ? 16'(-data_i.integral) : 16'(data_i.integral);
    prod  = {15'd0, i_mag} * {16'd0, Recip20};
    q20   = prod[29:19];
    q20s  = data_i.integral[15] ? -$signed({1'b0, q20}) : $signed({1'b0, q20});
    cmd   = {data_i.q25[11], data_i.q25} + {q20s[11], q20s};
    if (cmd > CmdLimit) begin
      cmd_c = CmdLimit;
    end else if (cmd < -CmdLimit) begin
      cmd_c = -CmdLimit;
    end else begin
      cmd_c = cmd;
    end
    cmd_mag = cmd_c[12] ? 7'(-cmd_c) : cmd_c[6:0];
    lvl2    = {cmd_mag, 1'b0};
    level_d = (lvl2 > {1'b0, DriveCap}) ? DriveCap : lvl2[6:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dir_q   <= cmd_c[12];
      level_q <= level_d;
      pos_q   <= data_i.position;
    end
  end

  assign valid_o       = valid_q;
  assign direction_o   = dir_q;
  assign drive_level_o = level_q;
  assign position_o    = pos_q;

endmodule

### hw/rtl/encoder_window_pi_position_regulator.sv
// Top level of the encoder window PI position regulator.
// Depends on ewpr_pkg, ewpr_if, ewpr_cfg, ewpr_window, ewpr_integ, ewpr_drive
// and the assertion macro header.
//
//   Channel | Direction | Transaction payload
//   req_i   | in        | raw_count[15:0], target_byte[7:0]
//   rsp_o   | out       | direction, drive_level[6:0], position[15:0]
//   APB     | in/out    | register writes and reads at byte addresses 0, 4 and 8
//
// One transaction is accepted per cycle while the window stage is ready.
// The pipeline has four register stages: window, reciprocal product, integral
// and output; the edge state updates at acceptance, the integral in stage three.
// Every stage has its own ready, so a stalled output only holds back full stages.
// Reset clears valid, edge, integral and config state at once; no clearing pass.
`include "encoder_window_pi_position_regulator_defines.svh"

module encoder_window_pi_position_regulator import ewpr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  ewpr_in_if.sink     req_i,
  ewpr_out_if.source  rsp_o
);

  cfg_t cfg;
  logic s1_valid, s1_ready, s3_valid, s3_ready;
  s1_t  s1_data;
  s3_t  s3_data;

  ewpr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ewpr_window u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .valid_i       (req_i.valid),
    .ready_o       (req_i.ready),
    .raw_count_i   (req_i.raw_count),
    .target_byte_i (req_i.target_byte),
    .valid_o       (s1_valid),
    .ready_i       (s1_ready),
    .data_o        (s1_data)
  );

  ewpr_integ u_integ (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s3_valid),
    .ready_i (s3_ready),
    .data_o  (s3_data)
  );

  ewpr_drive u_drive (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s3_valid),
    .ready_o       (s3_ready),
    .data_i        (s3_data),
    .valid_o       (rsp_o.valid),
    .ready_i       (rsp_o.ready),
    .direction_o   (rsp_o.direction),
    .drive_level_o (rsp_o.drive_level),
    .position_o    (rsp_o.position)
  );

  `EWPR_ASSERT_SAME(a_level_even, rsp_o.valid, rsp_o.drive_level[0] == 1'b0, "odd drive level")
  `EWPR_ASSERT_SAME(a_left_nonzero, rsp_o.valid && rsp_o.direction, rsp_o.drive_level != 7'd0, "left drive with zero level")
  `EWPR_ASSERT_SAME(a_stall_full, !req_i.ready, rsp_o.valid && !rsp_o.ready, "input stalled with room in the pipeline")
  `EWPR_ASSERT_NEXT(a_stage1_fill, req_i.valid && req_i.ready, s1_valid, "accepted transaction lost in stage one")

endmodule
